### hdl/lik_pkg.sv
// Leg inverse kinematics: shared constants, register indexes and CORDIC table.
// No dependencies; imported by lik_cordic and leg_inverse_kinematics.
`timescale 1ns / 1ps
`default_nettype none

package lik_pkg;

	// angles in Q16 radians through the CORDIC datapath
	localparam int ANG_W         = 19;
	localparam int CORDIC_STEPS  = 17;
	localparam int CORDIC_SCALE  = 16;
	localparam int CORDIC_LAT    = CORDIC_STEPS + 1;

	localparam int PI_Q16        = 205887;
	localparam int HALF_PI_Q16   = 102944;
	localparam int PI_Q13        = 25736;
	localparam int TWO_PI_Q13    = 51472;
	localparam int HALF_PI_Q13   = 12868;

	// atan(2^-i), Q16 radians
	localparam int ATAN_TAB [CORDIC_STEPS] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1
	};

	typedef enum logic [2:0] {
		REG_MOUNT_X     = 3'd0,
		REG_MOUNT_Y     = 3'd1,
		REG_MOUNT_Z     = 3'd2,
		REG_COXA_LEN    = 3'd3,
		REG_FEMUR_LEN   = 3'd4,
		REG_TIBIA_LEN   = 3'd5,
		REG_HIP_OFFSET  = 3'd6
	} cfg_reg_t;

endpackage

`default_nettype wire

### hdl/lik_isqrt.sv
// Pipelined integer square root, one result bit per stage (floor sqrt).
// Standalone; instantiated by leg_inverse_kinematics.
`timescale 1ns / 1ps
`default_nettype none

module lik_isqrt #(
	parameter int NW = 34
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [NW-1:0]           rad,
	output logic [(NW+1)/2-1:0]     root
);

	localparam int K  = (NW + 1) / 2;
	localparam int RW = 2 * K;

	logic [RW-1:0] n_s   [K];
	logic [RW-1:0] res_s [K];

	for (genvar k = 0; k < K; k++) begin : g_step
		logic [RW-1:0] ni, ri, bt, tb;

		if (k == 0) begin : g_first
			assign ni = RW'(rad);
			assign ri = '0;
		end else begin : g_next
			assign ni = n_s[k-1];
			assign ri = res_s[k-1];
		end

		assign bt = RW'(1) << (2 * (K - 1 - k));
		assign tb = ri + bt;

		always_ff @(posedge clk) begin
			if (en) begin
				if (ni >= tb) begin
					n_s[k]   <= ni - tb;
					res_s[k] <= (ri >> 1) + bt;
				end else begin
					n_s[k]   <= ni;
					res_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign root = res_s[K-1][K-1:0];

endmodule

`default_nettype wire

### hdl/lik_cordic.sv
// Pipelined atan2 in CORDIC vectoring mode, quadrant pre-rotation stage plus
// one micro-rotation per stage. Depends on lik_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lik_cordic #(
	parameter int IW = 18,
	parameter int W  = 40
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [IW-1:0]              xin,
	input  logic signed [IW-1:0]              yin,
	output logic signed [lik_pkg::ANG_W-1:0]  zout
);

	import lik_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic signed [W-1:0]     x_s  [N+1];
	logic signed [W-1:0]     y_s  [N+1];
	logic signed [ANG_W-1:0] z_s  [N+1];
	logic                    zf_s [N+1];

	logic signed [W-1:0]     xe, ye, x0, y0;
	logic signed [ANG_W-1:0] z0;

	assign xe = W'(xin);
	assign ye = W'(yin);

	// left half plane: rotate by +-pi/2 into the right half
	always_comb begin
		x0 = xe;
		y0 = ye;
		z0 = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				x0 = ye;
				y0 = -xe;
				z0 = ANG_W'(HALF_PI_Q16);
			end else begin
				x0 = -ye;
				y0 = xe;
				z0 = -ANG_W'(HALF_PI_Q16);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= x0 <<< CORDIC_SCALE;
			y_s[0]  <= y0 <<< CORDIC_SCALE;
			z_s[0]  <= z0;
			zf_s[0] <= (xin == '0) && (yin == '0);
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		localparam logic signed [ANG_W-1:0] TAB_K = ANG_W'(ATAN_TAB[k-1]);
		logic signed [W-1:0] dx, dy;

		assign dx = y_s[k-1] >>> (k - 1);
		assign dy = x_s[k-1] >>> (k - 1);

		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[k] <= zf_s[k-1];
				if (y_s[k-1] >= 0) begin
					x_s[k] <= x_s[k-1] + dx;
					y_s[k] <= y_s[k-1] - dy;
					z_s[k] <= z_s[k-1] + TAB_K;
				end else begin
					x_s[k] <= x_s[k-1] - dx;
					y_s[k] <= y_s[k-1] + dy;
					z_s[k] <= z_s[k-1] - TAB_K;
				end
			end
		end
	end

	assign zout = zf_s[N] ? '0 : z_s[N];

endmodule

`default_nettype wire

### hdl/leg_inverse_kinematics.sv
// Pipeline of bit-per-stage sqrt (17, 17, 29), divider (28) and CORDIC (18)
// stages; one item per cycle. The whole pipe advances when the output register
// is empty or taken, so throughput drops only while out_ready is low.
// Reset clears all valid bits and loads register defaults (femur and tibia 256, rest 0).
// Top level of the leg IK block; depends on lik_pkg, lik_isqrt, lik_cordic.
`timescale 1ns / 1ps
`default_nettype none

module leg_inverse_kinematics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] foot_x,
	input  logic signed [15:0] foot_y,
	input  logic signed [15:0] foot_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] hip_angle,
	output logic signed [14:0] femur_angle,
	output logic signed [15:0] tibia_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	import lik_pkg::*;

	// stage numbers (register stage after accept)
	localparam int P_A    = 1;
	localparam int P_SQ   = 2;
	localparam int P_RR   = 3;
	localparam int P_R    = P_RR + 17;
	localparam int P_D    = P_R + 1;
	localparam int P_D2   = P_D + 1;
	localparam int P_HH   = P_D2 + 1;
	localparam int P_H    = P_HH + 17;
	localparam int P_NUM  = P_H + 1;
	localparam int P_DIV0 = P_NUM + 1;
	localparam int P_Q    = P_DIV0 + 28;
	localparam int P_QQ   = P_Q + 1;
	localparam int P_ARG  = P_QQ + 1;
	localparam int P_S    = P_ARG + 29;
	localparam int P_ACOS = P_S + CORDIC_LAT;
	localparam int P_HIPZ = P_A + CORDIC_LAT;
	localparam int P_PZDZ = P_D + CORDIC_LAT;
	localparam int P_SUM  = P_ACOS + 1;
	localparam int P_CONV = P_SUM + 1;
	localparam int P_OUT  = P_CONV + 1;

	typedef struct packed {
		logic zero;
		logic is_pi;
		logic neg;
	} acos_flag_t;

	// ---------------- configuration ----------------
	logic signed [15:0] mount_x_q, mount_y_q, mount_z_q, hip_off_q;
	logic [14:0]        coxa_q, femur_q, tibia_q;
	logic [29:0]        ff_q, tt_q;
	logic [30:0]        ft2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_x_q <= '0;
			mount_y_q <= '0;
			mount_z_q <= '0;
			coxa_q    <= '0;
			femur_q   <= 15'd256;
			tibia_q   <= 15'd256;
			hip_off_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOUNT_X:    mount_x_q <= cfg_data;
				REG_MOUNT_Y:    mount_y_q <= cfg_data;
				REG_MOUNT_Z:    mount_z_q <= cfg_data;
				REG_COXA_LEN:   coxa_q    <= cfg_data[14:0];
				REG_FEMUR_LEN:  femur_q   <= cfg_data[14:0];
				REG_TIBIA_LEN:  tibia_q   <= cfg_data[14:0];
				REG_HIP_OFFSET: hip_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// link products, settle long before any item reaches them
	always_ff @(posedge clk) begin
		ff_q  <= 30'(femur_q) * 30'(femur_q);
		tt_q  <= 30'(tibia_q) * 30'(tibia_q);
		ft2_q <= {30'(femur_q) * 30'(tibia_q), 1'b0};
	end

	// ---------------- flow control ----------------
	logic [P_OUT-1:0] vld_q;
	logic             en;

	assign en        = !vld_q[P_OUT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[P_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[P_OUT-2:0], in_valid};
		end
	end

	// ---------------- leg frame, planar radius ----------------
	logic signed [16:0] px_s1, py_s1, pz_s1;
	logic signed [33:0] pxx, pyy, pzz;
	logic [31:0]        sx2_s2, sy2_s2, sz2_s2;
	logic [32:0]        rr_s3;
	logic [16:0]        r_root;

	assign pxx = px_s1 * px_s1;
	assign pyy = py_s1 * py_s1;
	assign pzz = pz_s1 * pz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= 17'(foot_x) - 17'(mount_x_q);
			py_s1  <= 17'(foot_y) - 17'(mount_y_q);
			pz_s1  <= 17'(foot_z) - 17'(mount_z_q);
			sx2_s2 <= pxx[31:0];
			sy2_s2 <= pyy[31:0];
			sz2_s2 <= pzz[31:0];
			rr_s3  <= 33'(sx2_s2) + 33'(sy2_s2);
		end
	end

	lik_isqrt #(.NW(33)) u_sqrt_r (
		.clk  (clk),
		.en   (en),
		.rad  (rr_s3),
		.root (r_root)
	);

	// hip bearing runs alongside the rest
	logic signed [ANG_W-1:0] hip_z;

	lik_cordic #(.IW(17), .W(40)) u_cordic_hip (
		.clk  (clk),
		.en   (en),
		.xin  (px_s1),
		.yin  (py_s1),
		.zout (hip_z)
	);

	// ---------------- femur/tibia triangle side ----------------
	logic signed [16:0] pz_s  [P_A+1:P_D];
	logic [31:0]        sz2_s [P_SQ+1:P_D2];
	logic signed [17:0] d_s21;
	logic signed [35:0] dd;
	logic [33:0]        d2_s22;
	logic [33:0]        hh_s23;
	logic [33:0]        hh_s  [P_HH+1:P_H];
	logic [16:0]        h_root;

	assign dd = d_s21 * d_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s[P_A+1] <= pz_s1;
			for (int j = P_A + 2; j <= P_D; j++) pz_s[j] <= pz_s[j-1];
			sz2_s[P_SQ+1] <= sz2_s2;
			for (int j = P_SQ + 2; j <= P_D2; j++) sz2_s[j] <= sz2_s[j-1];
			d_s21  <= 18'(r_root) - 18'(coxa_q);
			d2_s22 <= dd[33:0];
			hh_s23 <= 34'(sz2_s[P_D2]) + d2_s22;
			hh_s[P_HH+1] <= hh_s23;
			for (int j = P_HH + 2; j <= P_H; j++) hh_s[j] <= hh_s[j-1];
		end
	end

	lik_isqrt #(.NW(34)) u_sqrt_h (
		.clk  (clk),
		.en   (en),
		.rad  (hh_s23),
		.root (h_root)
	);

	logic signed [ANG_W-1:0] pzd_z;

	lik_cordic #(.IW(18), .W(40)) u_cordic_pzd (
		.clk  (clk),
		.en   (en),
		.xin  (d_s21),
		.yin  (18'(pz_s[P_D])),
		.zout (pzd_z)
	);

	// ---------------- law of cosines, lane 0 femur, lane 1 tibia ----------------
	logic signed [35:0] num_s41 [2];
	logic [32:0]        den_s41 [2];
	logic [31:0]        fh;

	assign fh = 32'(femur_q) * 32'(h_root);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s41[0] <= 36'(ff_q) - 36'(tt_q) + 36'(hh_s[P_H]);
			den_s41[0] <= {fh, 1'b0};
			num_s41[1] <= 36'(ff_q) + 36'(tt_q) - 36'(hh_s[P_H]);
			den_s41[1] <= 33'(ft2_q);
		end
	end

	logic signed [ANG_W-1:0] acos_z [2];
	acos_flag_t              fl_s   [2][P_DIV0:P_ACOS];
	logic [27:0]             qd_s   [2][P_Q+1:P_S];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [32:0]  rem_s [P_DIV0:P_Q];
		logic [32:0]  dv_s  [P_DIV0:P_Q];
		logic [27:0]  q_s   [P_DIV0:P_Q];
		logic signed [35:0] dn, nneg;
		logic [35:0]  mag;
		logic [55:0]  qq_s71;
		logic [56:0]  arg_s72;
		logic [28:0]  s_root;
		logic signed [29:0] qx, cx;

		assign dn   = 36'(den_s41[l]);
		assign nneg = -num_s41[l];
		assign mag  = num_s41[l][35] ? nneg : num_s41[l];

		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[l][P_DIV0] <= '{zero:  num_s41[l] >= dn,
				                     is_pi: nneg >= dn,
				                     neg:   num_s41[l][35]};
				for (int j = P_DIV0 + 1; j <= P_ACOS; j++) fl_s[l][j] <= fl_s[l][j-1];
				rem_s[P_DIV0] <= mag[32:0];
				dv_s[P_DIV0]  <= den_s41[l];
				q_s[P_DIV0]   <= '0;
			end
		end

		// restoring divide, one quotient bit per stage
		for (genvar k = P_DIV0 + 1; k <= P_Q; k++) begin : g_div
			logic [33:0] t;
			logic        ge;
			logic [33:0] diff;

			assign t    = {rem_s[k-1], 1'b0};
			assign ge   = t >= 34'(dv_s[k-1]);
			assign diff = t - 34'(dv_s[k-1]);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[32:0] : t[32:0];
					dv_s[k]  <= dv_s[k-1];
					q_s[k]   <= {q_s[k-1][26:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qq_s71  <= 56'(q_s[P_Q]) * 56'(q_s[P_Q]);
				arg_s72 <= (57'(1) << 56) - 57'(qq_s71);
				qd_s[l][P_Q+1] <= q_s[P_Q];
				for (int j = P_Q + 2; j <= P_S; j++) qd_s[l][j] <= qd_s[l][j-1];
			end
		end

		lik_isqrt #(.NW(57)) u_sqrt_s (
			.clk  (clk),
			.en   (en),
			.rad  (arg_s72),
			.root (s_root)
		);

		assign qx = 30'(qd_s[l][P_S]);
		assign cx = fl_s[l][P_S].neg ? -qx : qx;

		lik_cordic #(.IW(30), .W(48)) u_cordic_acos (
			.clk  (clk),
			.en   (en),
			.xin  (cx),
			.yin  (30'(s_root)),
			.zout (acos_z[l])
		);
	end

	// ---------------- angle sums, rounding, wrap, saturation ----------------
	logic signed [ANG_W-1:0] hipz_s [P_HIPZ+1:P_ACOS];
	logic signed [ANG_W-1:0] pzdz_s [P_PZDZ+1:P_ACOS];
	logic signed [ANG_W-1:0] acos_sel [2];
	logic signed [19:0]      hip_s120, fem_s120, tib_s120;
	logic signed [19:0]      hip_rnd, fem_rnd, tib_rnd;
	logic signed [17:0]      hip_s121, fem_s121, tib_s121;
	logic signed [17:0]      hip_w, fem_w, tib_w;
	logic signed [14:0]      hip_s122, fem_s122;
	logic signed [15:0]      tib_s122;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (fl_s[l][P_ACOS].zero)       acos_sel[l] = '0;
			else if (fl_s[l][P_ACOS].is_pi) acos_sel[l] = ANG_W'(PI_Q16);
			else                            acos_sel[l] = acos_z[l];
		end
	end

	// round Q16 to Q13: floor((v + 4) / 8)
	assign hip_rnd = (hip_s120 + 20'sd4) >>> 3;
	assign fem_rnd = (fem_s120 + 20'sd4) >>> 3;
	assign tib_rnd = (tib_s120 + 20'sd4) >>> 3;

	function automatic logic signed [17:0] wrap_q13(input logic signed [17:0] a);
		if (a > PI_Q13)        return a - 18'(TWO_PI_Q13);
		else if (a <= -PI_Q13) return a + 18'(TWO_PI_Q13);
		else                   return a;
	endfunction

	function automatic logic signed [17:0] sat_q13(input logic signed [17:0] a,
	                                               input int lo, input int hi);
		if (a < lo)      return 18'(lo);
		else if (a > hi) return 18'(hi);
		else             return a;
	endfunction

	assign hip_w = sat_q13(wrap_q13(hip_s121), -HALF_PI_Q13, HALF_PI_Q13);
	assign fem_w = sat_q13(wrap_q13(fem_s121), -HALF_PI_Q13, HALF_PI_Q13);
	assign tib_w = sat_q13(wrap_q13(tib_s121), -PI_Q13, 0);

	always_ff @(posedge clk) begin
		if (en) begin
			hipz_s[P_HIPZ+1] <= hip_z;
			for (int j = P_HIPZ + 2; j <= P_ACOS; j++) hipz_s[j] <= hipz_s[j-1];
			pzdz_s[P_PZDZ+1] <= pzd_z;
			for (int j = P_PZDZ + 2; j <= P_ACOS; j++) pzdz_s[j] <= pzdz_s[j-1];

			hip_s120 <= 20'(hipz_s[P_ACOS]);
			fem_s120 <= 20'(acos_sel[0]) + 20'(pzdz_s[P_ACOS]);
			tib_s120 <= 20'(acos_sel[1]) - 20'(PI_Q16);

			hip_s121 <= 18'(hip_rnd) - 18'(hip_off_q);
			fem_s121 <= 18'(fem_rnd);
			tib_s121 <= 18'(tib_rnd);

			hip_s122 <= hip_w[14:0];
			fem_s122 <= fem_w[14:0];
			tib_s122 <= tib_w[15:0];
		end
	end

	assign hip_angle   = hip_s122;
	assign femur_angle = fem_s122;
	assign tibia_angle = tib_s122;

endmodule

`default_nettype wire
